// ----- sv/sem_pkg.sv -----
// Package: shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int CntW      = $clog2(MaxWidth * (MaxHeight + 2)) + 1;
    localparam logic [7:0] SatLimit = 8'd255;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;

    typedef logic [23:0] pixel_t;

    // per-channel window taps, edge masks applied
    typedef struct packed {
        logic [8:0][7:0] tap;
    } chan_win_t;

endpackage

// ----- sv/sem_root.sv -----
// Module: per-channel Sobel sums and rounded square root, pipelined.
module sem_root
    import sem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  chan_win_t win,
    output logic [7:0] mag
);

    logic signed [11:0] gx_reg, gy_reg;
    logic signed [11:0] gx_next, gy_next;
    logic [21:0] sum_reg, sum_next;
    // digit-serial root: 8 pipeline steps, one bit each
    logic [21:0] s_pipe [0:8];
    logic [8:0]  n_pipe [0:8];

    // taps: 0..2 top row, 3..5 middle, 6..8 bottom; column left to right
    always_comb
    begin
        gx_next = 12'(win.tap[2]) - 12'(win.tap[0])
                + 12'({win.tap[5], 1'b0}) - 12'({win.tap[3], 1'b0})
                + 12'(win.tap[8]) - 12'(win.tap[6]);
        gy_next = 12'(win.tap[6]) + 12'({win.tap[7], 1'b0}) + 12'(win.tap[8])
                - 12'(win.tap[0]) - 12'({win.tap[1], 1'b0}) - 12'(win.tap[2]);
        sum_next = 22'(gx_reg * gx_reg) + 22'(gy_reg * gy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg  <= '0;
            gy_reg  <= '0;
            sum_reg <= '0;
        end
        else if (en)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            sum_reg <= sum_next;
        end
    end

    assign s_pipe[0] = sum_reg;
    assign n_pipe[0] = '0;

    // largest n with n*n - n + 1 <= s, built bit by bit from the top
    for (genvar b = 0; b < 8; b++)
    begin : g_bit
        logic [8:0]  cand;
        logic [19:0] sq;
        logic [21:0] s_r;
        logic [8:0]  n_r;
        assign cand = n_pipe[b] | (9'd1 << (7 - b));
        assign sq   = 20'(cand) * 20'(cand) - 20'(cand) + 20'd1;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_r <= '0;
                n_r <= '0;
            end
            else if (en)
            begin
                s_r <= s_pipe[b];
                n_r <= (22'(sq) <= s_pipe[b]) ? cand : n_pipe[b];
            end
        end
        assign s_pipe[b + 1] = s_r;
        assign n_pipe[b + 1] = n_r;
    end

    // n reaches at most 255 here; sums of 65026 and above saturate
    assign mag = (s_pipe[8] >= 22'd65026) ? SatLimit : n_pipe[8][7:0];

endmodule

// ----- sv/sobel_edge_magnitude.sv -----
// Top level: streaming 3x3 Sobel edge magnitude over RGB pixels.
//
//  channel | dir | beat content
//  s_axis  | in  | tuser=req_type, tdata=red,green,blue
//  m_axis  | out | tuser=frame_end, tdata=red,green,blue magnitudes
//  apb     | in  | image_width @0x0, image_height @0x4
//
// One item per cycle is accepted while the output can move. An item spends a
// line-store read stage, a window stage and a 10-stage sum/root pipeline ahead
// of the output register; results trail the input by image_width + 1 items.
// The whole pipeline advances only when its last stage can move; a full
// output register stalls the input. Line stores need no clearing after reset.
module sobel_edge_magnitude
    import sem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tuser,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int Lat = 11; // sum(1) + square(1) + root(8) + output align(1)

    logic [10:0] width_reg, height_reg;
    logic [CntW-1:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [CntW-1:0] w_eff, h_eff;
    pixel_t upper_mem [0:MaxWidth-1];
    pixel_t middle_mem [0:MaxWidth-1];
    pixel_t top_rd_reg, mid_rd_reg, px_reg;
    pixel_t win_reg [0:2][0:2];
    logic wb_vld_reg;
    logic [ColW-1:0] wb_col_reg;
    logic rd_vld_reg, rd_emit_reg, rd_last_reg;
    logic [3:0] rd_mask_reg;
    logic [Lat-2:0] vld_pipe_reg, last_pipe_reg;
    logic win_vld_reg, win_last_reg;
    logic [3:0] win_mask_reg;
    logic adv, take, cfg_wr, inputs_done, act, emit, last;
    logic [ColW-1:0] col;
    pixel_t px;
    chan_win_t cw [0:2];
    logic [7:0] mag [0:2];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            1'b0: prdata[10:0] = width_reg;
            default: prdata[10:0] = height_reg;
        endcase
    end

    // effective dimensions: zero acts as one, clamp at maximum
    assign w_eff = (width_reg == 0) ? CntW'(1) :
                   (width_reg > 11'(MaxWidth)) ? CntW'(MaxWidth) : CntW'(width_reg);
    assign h_eff = (height_reg == 0) ? CntW'(1) :
                   (height_reg > 11'(MaxHeight)) ? CntW'(MaxHeight) : CntW'(height_reg);

    // pipeline moves when the output slot is free or being taken
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign take = s_axis_tvalid && s_axis_tready;
    assign inputs_done = in_row_reg >= h_eff;
    assign act = take && (s_axis_tuser ? inputs_done : !inputs_done);
    assign px = s_axis_tuser ? '0 : s_axis_tdata[23:0];
    assign col = in_col_reg[ColW-1:0];
    // results start once w+1 items are in
    assign emit = act && ((in_row_reg > CntW'(1)) ||
                          ((in_row_reg == CntW'(1)) && (in_col_reg != '0)));
    assign last = (out_row_reg + 1'b1 >= h_eff) && (out_col_reg + 1'b1 >= w_eff);

    // line stores: registered reads; the upper line is written back in the cycle
    // after the read, forwarded when the next item reads the same column
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            top_rd_reg <= (wb_vld_reg && (wb_col_reg == col)) ? mid_rd_reg : upper_mem[col];
            mid_rd_reg <= middle_mem[col];
            middle_mem[col] <= px;
            px_reg <= px;
            wb_col_reg <= col;
        end
        if (wb_vld_reg)
            upper_mem[wb_col_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 11'd1024;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            wb_vld_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            rd_emit_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            rd_mask_reg <= '0;
            win_vld_reg <= 1'b0;
            win_last_reg <= 1'b0;
            win_mask_reg <= '0;
            vld_pipe_reg <= '0;
            last_pipe_reg <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tuser <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            wb_vld_reg <= act;
            if (cfg_wr)
            begin
                if (paddr[2:2] == RegWidth[0:0]) width_reg <= pwdata[10:0];
                else if (paddr[2:2] == RegHeight[0:0]) height_reg <= pwdata[10:0];
                in_col_reg <= '0;
                in_row_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (act)
            begin
                if (emit && last)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else
                begin
                    if (in_col_reg + 1'b1 >= w_eff)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end
                    else
                        in_col_reg <= in_col_reg + 1'b1;
                    if (emit)
                    begin
                        if (out_col_reg + 1'b1 >= w_eff)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end
                        else
                            out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
            if (adv)
            begin
                // stage 1: memory read out, masks captured
                rd_vld_reg <= act;
                rd_emit_reg <= emit;
                rd_last_reg <= last;
                rd_mask_reg <= {out_row_reg == 0, out_row_reg + 1'b1 >= h_eff,
                                out_col_reg == 0, out_col_reg + 1'b1 >= w_eff};
                // stage 2: window shift
                if (rd_vld_reg)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_rd_reg;
                    win_reg[1][2] <= mid_rd_reg;
                    win_reg[2][2] <= px_reg;
                end
                win_vld_reg <= rd_vld_reg && rd_emit_reg;
                win_last_reg <= rd_last_reg;
                win_mask_reg <= rd_mask_reg;
                vld_pipe_reg <= {vld_pipe_reg[Lat-3:0], win_vld_reg};
                last_pipe_reg <= {last_pipe_reg[Lat-3:0], win_last_reg};
                m_axis_tvalid <= vld_pipe_reg[Lat-2];
                m_axis_tuser <= last_pipe_reg[Lat-2];
            end
        end
    end

    // masked taps per channel
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    if ((r == 0 && win_mask_reg[3]) || (r == 2 && win_mask_reg[2]) ||
                        (c == 0 && win_mask_reg[1]) || (c == 2 && win_mask_reg[0]))
                        cw[ch].tap[r*3+c] = '0;
                    else
                        cw[ch].tap[r*3+c] = win_reg[r][c][8*ch +: 8];
                end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_ch
        sem_root u_root (
            .clk(clk), .rst_n(rst_n), .en(adv), .win(cw[ch]), .mag(mag[ch])
        );
    end

    // output data register: pipeline ends at root stage 8 plus one
    always_ff @(posedge clk)
    begin
        if (adv)
            m_axis_tdata <= {mag[2], mag[1], mag[0]};
    end

    // a stalled output beat must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    // config write always restarts counters
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> in_col_reg == 0 && in_row_reg == 0)
        else $error("counters not cleared by config write");
    // output position never runs ahead of input
    a_ord: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg <= in_row_reg)
        else $error("output position ahead of input");

endmodule
